// ===== rtl/hsv_to_rgb_assert.svh =====
// ----------------------------------------------------------------------------
// HSV to RGB assertion macros
// Shared concurrent assertion forms for the converter checkers.
// ----------------------------------------------------------------------------
`ifndef HSV_TO_RGB_ASSERT_SVH
`define HSV_TO_RGB_ASSERT_SVH

// Checked on every rising clock edge outside of reset.
`define H2R_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define H2R_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/h2r_pkg.sv =====
// ----------------------------------------------------------------------------
// HSV to RGB package
// Word types, fixed-point constants and small arithmetic helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package h2r_pkg;

   // Hue is given in units of 1/2^HUE_FRAC_BITS degree.
   localparam int unsigned HUE_FRAC_BITS = 4;
   localparam int unsigned HUE_W         = 13;
   localparam int unsigned CHAN_W        = 8;

   localparam int unsigned SEXT_UNITS = 60 << HUE_FRAC_BITS;
   localparam int unsigned REM_W      = $clog2(SEXT_UNITS);
   localparam int unsigned MAX_SEXT   = ((1 << HUE_W) - 1) / SEXT_UNITS;
   localparam int unsigned SEXT_W     = $clog2(MAX_SEXT + 1);

   // Fraction within a sextant, 16-bit fraction of one.
   localparam int unsigned FRAC_BITS  = 16;
   localparam int unsigned FRAC_SHIFT = 18;
   localparam longint unsigned FRAC_MUL =
      ((64'd1 << (FRAC_SHIFT + FRAC_BITS)) + SEXT_UNITS - 1) / SEXT_UNITS;
   localparam int unsigned FRAC_MUL_W = $clog2(FRAC_MUL + 1);
   localparam int unsigned FPROD_W    = REM_W + FRAC_MUL_W;

   // 255 * 2^16, the denominator of the scaled channels.
   localparam int unsigned FULL_W = CHAN_W + FRAC_BITS;
   localparam logic [FULL_W-1:0] FULL_SCALE = FULL_W'(255 << FRAC_BITS);

   // floor(y / 255) for 16-bit y as a reciprocal multiply.
   localparam int unsigned DIV255_SHIFT = 23;
   localparam logic [15:0] DIV255_MUL   = 16'd32897;

   // Sextant codes that pick a channel order; anything else uses red-yellow.
   localparam logic [SEXT_W-1:0] SEXT_RED_YEL   = SEXT_W'(0);
   localparam logic [SEXT_W-1:0] SEXT_YEL_GRN   = SEXT_W'(1);
   localparam logic [SEXT_W-1:0] SEXT_GRN_CYN   = SEXT_W'(2);
   localparam logic [SEXT_W-1:0] SEXT_CYN_BLU   = SEXT_W'(3);
   localparam logic [SEXT_W-1:0] SEXT_BLU_MAG   = SEXT_W'(4);
   localparam logic [SEXT_W-1:0] SEXT_MAG_RED   = SEXT_W'(5);

   typedef struct packed {
      logic [CHAN_W-1:0] saturation;
      logic [CHAN_W-1:0] brightness;
   } req_word_type;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } rsp_word_type;

   function automatic logic [CHAN_W-1:0] div255(input logic [15:0] y);
      logic [31:0] prod;
      prod = 32'(y) * 32'(DIV255_MUL);
      return prod[DIV255_SHIFT +: CHAN_W];
   endfunction

endpackage

// ===== rtl/hsv_to_rgb.sv =====
// ----------------------------------------------------------------------------
// HSV to RGB converter
// Throughput: one word per cycle; each of the six register stages holds one
// word and only a stalled output makes the stages ahead of it wait.
// Reset clears every stage valid bit and sets the hue register to zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hsv_to_rgb (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write_en,
   input  logic [h2r_pkg::HUE_W-1:0]      csr_write_data,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  h2r_pkg::req_word_type          req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output h2r_pkg::rsp_word_type          rsp_data
);

   // The hue is a single register shared by every word. Software writes it
   // only while the pipeline is empty; the block itself does not enforce this.
   // Only stage 1 reads it; later stages carry the sextant and remainder.
   logic [h2r_pkg::HUE_W-1:0] hue_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         hue_ff <= '0;
      end else if (csr_write_en) begin
         hue_ff <= csr_write_data;
      end
   end

   // Flow control: a stage takes a new word when it is empty or when the
   // stage after it is taking its word this cycle. Valid bits move with data.
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, s5_valid_ff;
   logic out_valid_ff;
   logic s1_ready, s2_ready, s3_ready, s4_ready, s5_ready, out_ready;

   assign out_ready = !out_valid_ff || rsp_ready;
   assign s5_ready  = !s5_valid_ff  || out_ready;
   assign s4_ready  = !s4_valid_ff  || s5_ready;
   assign s3_ready  = !s3_valid_ff  || s4_ready;
   assign s2_ready  = !s2_valid_ff  || s3_ready;
   assign s1_ready  = !s1_valid_ff  || s2_ready;
   assign req_ready = s1_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         s5_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (s1_ready)  s1_valid_ff  <= req_valid;
         if (s2_ready)  s2_valid_ff  <= s1_valid_ff;
         if (s3_ready)  s3_valid_ff  <= s2_valid_ff;
         if (s4_ready)  s4_valid_ff  <= s3_valid_ff;
         if (s5_ready)  s5_valid_ff  <= s4_valid_ff;
         if (out_ready) out_valid_ff <= s5_valid_ff;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 1: split the hue into a sextant and the remainder inside it.
   // The sextant count is a bank of parallel compares against multiples of
   // sixty degrees; hues of 360 degrees and beyond give sextants six and up.
   // ------------------------------------------------------------------------
   logic [h2r_pkg::SEXT_W-1:0] sext_in;
   logic [h2r_pkg::HUE_W-1:0]  rem_wide;

   always_comb begin
      sext_in  = '0;
      rem_wide = hue_ff;
      for (int unsigned k = 1; k <= h2r_pkg::MAX_SEXT; k++) begin
         if (hue_ff >= h2r_pkg::HUE_W'(k * h2r_pkg::SEXT_UNITS)) begin
            sext_in  = h2r_pkg::SEXT_W'(k);
            rem_wide = hue_ff - h2r_pkg::HUE_W'(k * h2r_pkg::SEXT_UNITS);
         end
      end
   end

   logic [h2r_pkg::CHAN_W-1:0] s1_sat_ff, s1_bri_ff;
   logic [h2r_pkg::SEXT_W-1:0] s1_sext_ff;
   logic [h2r_pkg::REM_W-1:0]  s1_rem_ff;

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_sat_ff  <= req_data.saturation;
         s1_bri_ff  <= req_data.brightness;
         s1_sext_ff <= sext_in;
         s1_rem_ff  <= rem_wide[h2r_pkg::REM_W-1:0];
      end
   end

   // ------------------------------------------------------------------------
   // Stage 2: f = floor(rem * 65536 / sextant width), done as a multiply by
   // a rounded-up reciprocal. The low-order error never reaches the next
   // integer because rem * 65536 / 960 has a fraction of at most 14/15.
   // ------------------------------------------------------------------------
   logic [h2r_pkg::FPROD_W-1:0] fprod_in;

   assign fprod_in = h2r_pkg::FPROD_W'(s1_rem_ff)
                   * h2r_pkg::FPROD_W'(h2r_pkg::FRAC_MUL);

   logic [h2r_pkg::CHAN_W-1:0]  s2_sat_ff, s2_bri_ff;
   logic [h2r_pkg::SEXT_W-1:0]  s2_sext_ff;
   logic [h2r_pkg::FPROD_W-1:0] s2_fprod_ff;

   always_ff @(posedge clock) begin
      if (s2_ready) begin
         s2_sat_ff   <= s1_sat_ff;
         s2_bri_ff   <= s1_bri_ff;
         s2_sext_ff  <= s1_sext_ff;
         s2_fprod_ff <= fprod_in;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 3: scale the fraction by saturation. s*f feeds q, s*(1-f) feeds
   // t, and v*(255-s) is the numerator of p.
   // ------------------------------------------------------------------------
   logic [h2r_pkg::FRAC_BITS-1:0] frac;
   logic [h2r_pkg::FRAC_BITS:0]   frac_comp;
   logic [h2r_pkg::FULL_W-1:0]    sf_in;
   logic [h2r_pkg::FULL_W:0]      st_in;
   logic [2*h2r_pkg::CHAN_W-1:0]  pnum_in;
   logic [h2r_pkg::CHAN_W-1:0]    sat_comp;

   assign frac      = s2_fprod_ff[h2r_pkg::FRAC_SHIFT +: h2r_pkg::FRAC_BITS];
   assign frac_comp = (h2r_pkg::FRAC_BITS+1)'(1 << h2r_pkg::FRAC_BITS)
                    - (h2r_pkg::FRAC_BITS+1)'(frac);
   assign sat_comp  = 8'd255 - s2_sat_ff;
   assign sf_in     = h2r_pkg::FULL_W'(s2_sat_ff) * h2r_pkg::FULL_W'(frac);
   assign st_in     = (h2r_pkg::FULL_W+1)'(s2_sat_ff)
                    * (h2r_pkg::FULL_W+1)'(frac_comp);
   assign pnum_in   = (2*h2r_pkg::CHAN_W)'(s2_bri_ff) * (2*h2r_pkg::CHAN_W)'(sat_comp);

   logic [h2r_pkg::CHAN_W-1:0]   s3_bri_ff;
   logic [h2r_pkg::SEXT_W-1:0]   s3_sext_ff;
   logic [h2r_pkg::FULL_W-1:0]   s3_sf_ff;
   logic [h2r_pkg::FULL_W:0]     s3_st_ff;
   logic [2*h2r_pkg::CHAN_W-1:0] s3_pnum_ff;

   always_ff @(posedge clock) begin
      if (s3_ready) begin
         s3_bri_ff  <= s2_bri_ff;
         s3_sext_ff <= s2_sext_ff;
         s3_sf_ff   <= sf_in;
         s3_st_ff   <= st_in;
         s3_pnum_ff <= pnum_in;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 4: numerators v * (255*65536 - s*f) for q and v * (255*65536 - s*(1-f))
   // for t, neither negative since s*f and s*(1-f) never exceed 255*65536. Dropping
   // the low sixteen bits is the first half of the divide by 255*65536.
   // ------------------------------------------------------------------------
   logic [h2r_pkg::FULL_W-1:0] dq, dt;
   logic [31:0]                numq, numt;
   logic [h2r_pkg::FULL_W:0]   dt_wide;

   assign dq      = h2r_pkg::FULL_SCALE - s3_sf_ff;
   assign dt_wide = (h2r_pkg::FULL_W+1)'(h2r_pkg::FULL_SCALE) - s3_st_ff;
   assign dt      = dt_wide[h2r_pkg::FULL_W-1:0];
   assign numq    = 32'(s3_bri_ff) * 32'(dq);
   assign numt    = 32'(s3_bri_ff) * 32'(dt);

   logic [h2r_pkg::CHAN_W-1:0]   s4_bri_ff;
   logic [h2r_pkg::SEXT_W-1:0]   s4_sext_ff;
   logic [2*h2r_pkg::CHAN_W-1:0] s4_yq_ff, s4_yt_ff, s4_yp_ff;

   always_ff @(posedge clock) begin
      if (s4_ready) begin
         s4_bri_ff  <= s3_bri_ff;
         s4_sext_ff <= s3_sext_ff;
         s4_yq_ff   <= numq[31:h2r_pkg::FRAC_BITS];
         s4_yt_ff   <= numt[31:h2r_pkg::FRAC_BITS];
         s4_yp_ff   <= s3_pnum_ff;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 5: the remaining divide by 255 for p, q and t. Truncating twice is
   // the same as truncating once, so the split divide is exact.
   // ------------------------------------------------------------------------
   logic [h2r_pkg::CHAN_W-1:0] s5_bri_ff, s5_q_ff, s5_t_ff, s5_p_ff;
   logic [h2r_pkg::SEXT_W-1:0] s5_sext_ff;

   always_ff @(posedge clock) begin
      if (s5_ready) begin
         s5_bri_ff  <= s4_bri_ff;
         s5_sext_ff <= s4_sext_ff;
         s5_q_ff    <= h2r_pkg::div255(s4_yq_ff);
         s5_t_ff    <= h2r_pkg::div255(s4_yt_ff);
         s5_p_ff    <= h2r_pkg::div255(s4_yp_ff);
      end
   end

   // ------------------------------------------------------------------------
   // Stage 6: channel order for the sextant, into the output register. Hues
   // of 360 degrees and beyond fall through to the red-yellow order.
   // ------------------------------------------------------------------------
   h2r_pkg::rsp_word_type rsp_data_in, rsp_data_ff;

   always_comb begin
      unique case (s5_sext_ff)
         h2r_pkg::SEXT_YEL_GRN: rsp_data_in = '{s5_q_ff,   s5_bri_ff, s5_p_ff};
         h2r_pkg::SEXT_GRN_CYN: rsp_data_in = '{s5_p_ff,   s5_bri_ff, s5_t_ff};
         h2r_pkg::SEXT_CYN_BLU: rsp_data_in = '{s5_p_ff,   s5_q_ff,   s5_bri_ff};
         h2r_pkg::SEXT_BLU_MAG: rsp_data_in = '{s5_t_ff,   s5_p_ff,   s5_bri_ff};
         h2r_pkg::SEXT_MAG_RED: rsp_data_in = '{s5_bri_ff, s5_p_ff,   s5_q_ff};
         default:               rsp_data_in = '{s5_bri_ff, s5_t_ff,   s5_p_ff};
      endcase
   end

   always_ff @(posedge clock) begin
      if (out_ready) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== rtl/h2r_checker.sv =====
// ----------------------------------------------------------------------------
// HSV to RGB port checker
// Watches the converter ports for output handshake and flow-control slips.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "hsv_to_rgb_assert.svh"

module h2r_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input h2r_pkg::rsp_word_type     rsp_data
);

   // A result word waiting on the consumer stays put.
   `H2R_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data), "result word changed while stalled")

   // With the output register empty no stage can be blocked.
   `H2R_ASSERT(a_empty_ready, clock, reset, !rsp_valid |-> req_ready, "request stalled with an empty output")

   // Nothing comes out in the cycle after reset is released.
   `H2R_ASSERT_ALWAYS(a_reset_quiet, clock, $past(reset) && !reset |-> !rsp_valid, "result word right after reset")

endmodule

bind hsv_to_rgb h2r_checker u_h2r_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_data       (rsp_data)
);
